### rtl/lfk_pkg.sv
`default_nettype none

package lfk_pkg;

    localparam int TRIG_STAGES_DEF = 16;
    localparam int COUNT_BITS_DEF  = 24;

    localparam int ENC_W   = 24;
    localparam int GAIN_W  = 24;
    localparam int LEN_W   = 16;
    localparam int OFS_W   = 16;
    localparam int PACK_W  = 48;
    localparam int ANGLE_W = 16;
    localparam int COORD_W = 18;
    localparam int PHASE_W = 32;
    localparam int CFG_W   = 48;
    localparam int IDX_W   = 3;
    localparam int LANES   = 3;

    // CORDIC datapath width, headroom above Q30 for the CORDIC gain
    localparam int CW = 34;
    // working width of lengths and coordinates before saturation
    localparam int PW = 20;

    typedef logic signed [CW-1:0] t_cval;

    localparam logic [IDX_W-1:0] REG_BASE_HEIGHT = 3'd0;
    localparam logic [IDX_W-1:0] REG_LINK_B      = 3'd1;
    localparam logic [IDX_W-1:0] REG_LINK_C      = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN_A      = 3'd3;
    localparam logic [IDX_W-1:0] REG_GAIN_B      = 3'd4;
    localparam logic [IDX_W-1:0] REG_GAIN_C      = 3'd5;
    localparam logic [IDX_W-1:0] REG_HOME        = 3'd6;
    localparam logic [IDX_W-1:0] REG_ORIGIN      = 3'd7;

    localparam logic [LEN_W-1:0]  RST_BASE_HEIGHT = 16'd5243;
    localparam logic [LEN_W-1:0]  RST_LINK_B      = 16'd13435;
    localparam logic [LEN_W-1:0]  RST_LINK_C      = 16'd16056;
    localparam logic [GAIN_W-1:0] RST_GAIN_A      = 24'd134218;
    localparam logic [GAIN_W-1:0] RST_GAIN_B      = 24'hFD44F3;
    localparam logic [GAIN_W-1:0] RST_GAIN_C      = 24'hFD44F3;
    localparam logic [PACK_W-1:0] RST_HOME        = 48'd255705172934656;
    localparam logic [PACK_W-1:0] RST_ORIGIN      = 48'd22518513547346;

    localparam t_cval CORDIC_X0 = 34'sd652032874;

    localparam logic signed [PW:0] COORD_MAX = 21'sd131071;
    localparam logic signed [PW:0] COORD_MIN = -21'sd131072;

    function automatic logic signed [PHASE_W-1:0] atan_turn(input logic [4:0] idx);
        logic signed [PHASE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10679838;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat18(input logic signed [PW:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > COORD_MAX) begin
            r = COORD_MAX[COORD_W-1:0];
        end else if (v < COORD_MIN) begin
            r = COORD_MIN[COORD_W-1:0];
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/lfk_cordic.sv
`default_nettype none

module lfk_cordic #(
    parameter int TRIG_STAGES = lfk_pkg::TRIG_STAGES_DEF
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_en,
    input  wire logic                                         i_valid,
    input  wire logic [lfk_pkg::LANES-1:0][lfk_pkg::PHASE_W-1:0] i_phase,
    output logic                                              o_valid,
    output lfk_pkg::t_cval                                    o_cos [lfk_pkg::LANES],
    output lfk_pkg::t_cval                                    o_sin [lfk_pkg::LANES],
    output logic [lfk_pkg::LANES-1:0][lfk_pkg::ANGLE_W-1:0]   o_angle
);
    import lfk_pkg::*;

    localparam int N = TRIG_STAGES;

    // stage 0 is the quadrant reduction, stages 1..N the rotations
    logic  r_v   [N+1];
    t_cval r_x   [N+1][LANES];
    t_cval r_y   [N+1][LANES];
    t_cval r_z   [N+1][LANES];
    logic [1:0]         r_q   [N+1][LANES];
    logic [ANGLE_W-1:0] r_ang [N+1][LANES];

    logic               r_vo;
    t_cval              r_cos [LANES];
    t_cval              r_sin [LANES];
    logic [ANGLE_W-1:0] r_ango [LANES];

    // quadrant reduction
    for (genvar l = 0; l < LANES; l++) begin : g_red
        logic [PHASE_W-1:0] w_rq;
        logic [1:0]         w_q;
        logic [PHASE_W-1:0] w_z;
        logic [PHASE_W-1:0] w_ar;
        assign w_rq = i_phase[l] + 32'h2000_0000;
        assign w_q  = w_rq[PHASE_W-1:PHASE_W-2];
        assign w_z  = i_phase[l] - {w_q, 30'd0};
        assign w_ar = i_phase[l] + 32'h0000_8000;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[0][l]   <= CORDIC_X0;
                r_y[0][l]   <= '0;
                r_z[0][l]   <= CW'($signed(w_z));
                r_q[0][l]   <= w_q;
                r_ang[0][l] <= w_ar[PHASE_W-1:PHASE_W-ANGLE_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    for (genvar s = 0; s < N; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            t_cval w_dx;
            t_cval w_dy;
            t_cval w_at;
            assign w_dx = r_y[s][l] >>> s;
            assign w_dy = r_x[s][l] >>> s;
            assign w_at = CW'(atan_turn(5'(s)));
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_z[s][l][CW-1]) begin
                        r_x[s+1][l] <= r_x[s][l] - w_dx;
                        r_y[s+1][l] <= r_y[s][l] + w_dy;
                        r_z[s+1][l] <= r_z[s][l] - w_at;
                    end else begin
                        r_x[s+1][l] <= r_x[s][l] + w_dx;
                        r_y[s+1][l] <= r_y[s][l] - w_dy;
                        r_z[s+1][l] <= r_z[s][l] + w_at;
                    end
                    r_q[s+1][l]   <= r_q[s][l];
                    r_ang[s+1][l] <= r_ang[s][l];
                end
            end
        end
    end

    // move back into the quadrant
    for (genvar l = 0; l < LANES; l++) begin : g_map
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                unique case (r_q[N][l])
                    2'd0: begin
                        r_cos[l] <= r_x[N][l];
                        r_sin[l] <= r_y[N][l];
                    end
                    2'd1: begin
                        r_cos[l] <= -r_y[N][l];
                        r_sin[l] <= r_x[N][l];
                    end
                    2'd2: begin
                        r_cos[l] <= -r_x[N][l];
                        r_sin[l] <= -r_y[N][l];
                    end
                    default: begin
                        r_cos[l] <= r_y[N][l];
                        r_sin[l] <= -r_x[N][l];
                    end
                endcase
                r_ango[l] <= r_ang[N][l];
            end
        end
        assign o_cos[l]   = r_cos[l];
        assign o_sin[l]   = r_sin[l];
        assign o_angle[l] = r_ango[l];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_v[N];
        end
    end

    assign o_valid = r_vo;

`ifndef SYNTHESIS
    property p_frozen;
        @(posedge i_clk) disable iff (!i_rst_n) !i_en |=> $stable(r_vo);
    endproperty
    a_frozen: assert property (p_frozen) else $error("cordic moved while frozen");

    property p_reset_clear;
        @(posedge i_clk) !i_rst_n |=> !r_vo && !r_v[0];
    endproperty
    a_reset_clear: assert property (p_reset_clear) else $error("cordic valid after reset");

    property p_entry;
        @(posedge i_clk) disable iff (!i_rst_n) (i_en && i_valid) |=> r_v[0];
    endproperty
    a_entry: assert property (p_entry) else $error("cordic lost an item at entry");
`endif

endmodule

`default_nettype wire

### rtl/linkage_forward_kinematics_unit.sv
`default_nettype none

// Channel  Direction  Handshake           Payload
// input    in         i_valid / o_stall   i_encoder_a, i_encoder_b, i_encoder_c
// result   out        o_valid / i_stall   o_angle_*, o_elbow_*, o_tip_*, o_tip_ws_*
// config   in         i_cfg_wr_en         i_cfg_index, i_cfg_data
//
// One item per cycle while the sink does not stall; the CORDIC stages set most of the pipeline depth.
// Synchronous active-low reset clears valid bits and loads register defaults.
// A stalled result freezes the whole pipeline; o_stall rises only while a
// result waits and the sink stalls, so no item is dropped or repeated.

module linkage_forward_kinematics_unit #(
    parameter int TRIG_STAGES = lfk_pkg::TRIG_STAGES_DEF,
    parameter int COUNT_BITS  = lfk_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [lfk_pkg::IDX_W-1:0]           i_cfg_index,
    input  wire logic [lfk_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [lfk_pkg::ENC_W-1:0]    i_encoder_a,
    input  wire logic signed [lfk_pkg::ENC_W-1:0]    i_encoder_b,
    input  wire logic signed [lfk_pkg::ENC_W-1:0]    i_encoder_c,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [lfk_pkg::ANGLE_W-1:0]              o_angle_a,
    output logic [lfk_pkg::ANGLE_W-1:0]              o_angle_b,
    output logic [lfk_pkg::ANGLE_W-1:0]              o_angle_c,
    output logic signed [lfk_pkg::COORD_W-1:0]       o_elbow_x,
    output logic signed [lfk_pkg::COORD_W-1:0]       o_elbow_y,
    output logic signed [lfk_pkg::COORD_W-1:0]       o_elbow_z,
    output logic signed [lfk_pkg::COORD_W-1:0]       o_tip_x,
    output logic signed [lfk_pkg::COORD_W-1:0]       o_tip_y,
    output logic signed [lfk_pkg::COORD_W-1:0]       o_tip_z,
    output logic signed [lfk_pkg::COORD_W-1:0]       o_tip_ws_x,
    output logic signed [lfk_pkg::COORD_W-1:0]       o_tip_ws_y,
    output logic signed [lfk_pkg::COORD_W-1:0]       o_tip_ws_z
);
    import lfk_pkg::*;

    localparam int PROD_W = COUNT_BITS + GAIN_W;

    function automatic logic signed [PW-1:0] rnd30(input logic signed [55:0] p);
        logic signed [55:0] t;
        t = p + (56'sd1 <<< 29);
        return t[PW+29:30];
    endfunction

    // configuration registers
    logic [LEN_W-1:0]  r_base_height, r_link_b, r_link_c;
    logic [GAIN_W-1:0] r_gain [LANES];
    logic [PACK_W-1:0] r_home, r_origin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_height <= RST_BASE_HEIGHT;
            r_link_b      <= RST_LINK_B;
            r_link_c      <= RST_LINK_C;
            r_gain[0]     <= RST_GAIN_A;
            r_gain[1]     <= RST_GAIN_B;
            r_gain[2]     <= RST_GAIN_C;
            r_home        <= RST_HOME;
            r_origin      <= RST_ORIGIN;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_BASE_HEIGHT: r_base_height <= i_cfg_data[LEN_W-1:0];
                REG_LINK_B:      r_link_b      <= i_cfg_data[LEN_W-1:0];
                REG_LINK_C:      r_link_c      <= i_cfg_data[LEN_W-1:0];
                REG_GAIN_A:      r_gain[0]     <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_B:      r_gain[1]     <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_C:      r_gain[2]     <= i_cfg_data[GAIN_W-1:0];
                REG_HOME:        r_home        <= i_cfg_data[PACK_W-1:0];
                default:         r_origin      <= i_cfg_data[PACK_W-1:0];
            endcase
        end
    end

    logic en;
    logic r_v1, r_v2, r_v4, r_v5, r_v6;
    logic cordic_valid;

    assign en      = !(r_v6 && i_stall);
    assign o_stall = !en;
    assign o_valid = r_v6;

    // stage 1: home offset, wrap to count width
    logic signed [ENC_W-1:0]      enc [LANES];
    logic signed [COUNT_BITS-1:0] r_count [LANES];

    assign enc[0] = i_encoder_a;
    assign enc[1] = i_encoder_b;
    assign enc[2] = i_encoder_c;

    for (genvar l = 0; l < LANES; l++) begin : g_s1
        logic signed [32:0] w_sum;
        assign w_sum = 33'(enc[l]) + 33'($signed(r_home[OFS_W*l +: OFS_W]));
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_count[l] <= w_sum[COUNT_BITS-1:0];
            end
        end
    end

    // stage 2: angle per count
    logic [LANES-1:0][PHASE_W-1:0] r_phase;

    for (genvar l = 0; l < LANES; l++) begin : g_s2
        logic signed [PROD_W-1:0] w_prod;
        assign w_prod = PROD_W'(r_count[l]) * PROD_W'($signed(r_gain[l]));
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_phase[l] <= w_prod[PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v4 <= cordic_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    t_cval                              cos_v [LANES];
    t_cval                              sin_v [LANES];
    logic [LANES-1:0][ANGLE_W-1:0]      angle_v;

    lfk_cordic #(
        .TRIG_STAGES (TRIG_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v2),
        .i_phase (r_phase),
        .o_valid (cordic_valid),
        .o_cos   (cos_v),
        .o_sin   (sin_v),
        .o_angle (angle_v)
    );

    // stage 4: body projections
    logic signed [PW-1:0]  r_bs, r_bc, r_cs, r_cc;
    t_cval                 r_ca4, r_sa4;
    logic [ANGLE_W-1:0]    r_ang4 [LANES];
    logic signed [LEN_W:0] lb, lc;

    assign lb = $signed({1'b0, r_link_b});
    assign lc = $signed({1'b0, r_link_c});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bs  <= rnd30(56'(lb) * 56'(sin_v[1]));
            r_bc  <= rnd30(56'(lb) * 56'(cos_v[1]));
            r_cs  <= rnd30(56'(lc) * 56'(sin_v[2]));
            r_cc  <= rnd30(56'(lc) * 56'(cos_v[2]));
            r_ca4 <= cos_v[0];
            r_sa4 <= sin_v[0];
            for (int l = 0; l < LANES; l++) begin
                r_ang4[l] <= angle_v[l];
            end
        end
    end

    // stage 5: elbow and tip
    logic signed [PW:0]    reach;
    logic signed [PW-1:0]  ln;
    logic signed [PW-1:0]  r_ex, r_ey, r_ez, r_tx, r_ty, r_tz;
    logic [ANGLE_W-1:0]    r_ang5 [LANES];

    assign reach = (PW+1)'(r_bs) + (PW+1)'(r_cs);
    assign ln    = PW'(r_base_height);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ex <= rnd30(56'(r_ca4) * 56'(r_bs));
            r_ey <= rnd30(56'(r_sa4) * 56'(r_bs));
            r_ez <= ln + r_bc;
            r_tx <= rnd30(56'(r_ca4) * 56'(reach));
            r_ty <= rnd30(56'(r_sa4) * 56'(reach));
            r_tz <= ln + r_bc - r_cc;
            for (int l = 0; l < LANES; l++) begin
                r_ang5[l] <= r_ang4[l];
            end
        end
    end

    // stage 6: workspace offset and saturation
    logic signed [PW:0] org_x, org_y, org_z;

    assign org_x = (PW+1)'($signed(r_origin[OFS_W-1:0]));
    assign org_y = (PW+1)'($signed(r_origin[2*OFS_W-1:OFS_W]));
    assign org_z = (PW+1)'($signed(r_origin[3*OFS_W-1:2*OFS_W]));

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_angle_a  <= r_ang5[0];
            o_angle_b  <= r_ang5[1];
            o_angle_c  <= r_ang5[2];
            o_elbow_x  <= sat18((PW+1)'(r_ex));
            o_elbow_y  <= sat18((PW+1)'(r_ey));
            o_elbow_z  <= sat18((PW+1)'(r_ez));
            o_tip_x    <= sat18((PW+1)'(r_tx));
            o_tip_y    <= sat18((PW+1)'(r_ty));
            o_tip_z    <= sat18((PW+1)'(r_tz));
            o_tip_ws_x <= sat18((PW+1)'(r_tx) - org_x);
            o_tip_ws_y <= sat18((PW+1)'(r_ty) - org_y);
            o_tip_ws_z <= sat18((PW+1)'(r_tz) - org_z);
        end
    end

`ifndef SYNTHESIS
    property p_take;
        @(posedge i_clk) disable iff (!i_rst_n) (i_valid && !o_stall) |=> r_v1;
    endproperty
    a_take: assert property (p_take) else $error("accepted item not captured");

    property p_freeze;
        @(posedge i_clk) disable iff (!i_rst_n) o_stall |=> $stable(r_phase) && r_v6;
    endproperty
    a_freeze: assert property (p_freeze) else $error("pipeline moved during stall");

    property p_reset_out;
        @(posedge i_clk) !i_rst_n |=> !o_valid;
    endproperty
    a_reset_out: assert property (p_reset_out) else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

### bench/linkage_forward_kinematics_unit_test.sv
`timescale 1ns / 100ps

module linkage_forward_kinematics_unit_test;
    import lfk_pkg::*;

    localparam int STAGES = TRIG_STAGES_DEF;
    localparam int CBITS  = COUNT_BITS_DEF;

    typedef struct {
        logic [15:0] ang_a, ang_b, ang_c;
        logic signed [17:0] ex, ey, ez, tx, ty, tz, wx, wy, wz;
    } t_pose;

    logic i_clk, i_rst_n, i_cfg_wr_en, i_valid, i_stall;
    logic [IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;
    logic signed [ENC_W-1:0] i_encoder_a, i_encoder_b, i_encoder_c;
    wire o_stall, o_valid;
    wire [15:0] o_angle_a, o_angle_b, o_angle_c;
    wire signed [17:0] o_elbow_x, o_elbow_y, o_elbow_z, o_tip_x, o_tip_y, o_tip_z;
    wire signed [17:0] o_tip_ws_x, o_tip_ws_y, o_tip_ws_z;

    linkage_forward_kinematics_unit dut (.*);

    // shadow copy of the configuration registers
    logic [47:0] cfg_shadow [8];
    t_pose expected_poses [$];
    int errors = 0;
    int poses_checked = 0;
    int items_sent = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint asr_l(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_q30(longint p);
        return (p + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic logic signed [17:0] clamp18(longint v);
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        return v[17:0];
    endfunction

    function automatic logic [31:0] body_phase(logic [23:0] enc, int axis);
        longint e, h, cnt, g, prod;
        logic [15:0] hv;
        logic [CBITS-1:0] cw;
        e = longint'($signed(enc));
        hv = 16'(cfg_shadow[REG_HOME] >> (16 * axis));
        h = longint'($signed(hv));
        cw = CBITS'(e + h);
        cnt = longint'($signed(cw));
        g = longint'($signed(cfg_shadow[REG_GAIN_A + axis][23:0]));
        prod = cnt * g;
        return prod[31:0];
    endfunction

    task automatic trig(input logic [31:0] ph, output longint c, output longint s);
        logic [31:0] q, r;
        longint z, x, y, dx, dy, ta;
        int i;
        q = ((ph + 32'h2000_0000) >> 30) & 32'd3;
        r = ph - (q << 30);
        z = longint'($signed(r));
        x = 652032874;
        y = 0;
        for (i = 0; i < STAGES && i < 24; i++) begin
            dx = asr_l(y, i);
            dy = asr_l(x, i);
            ta = longint'(atan_turn(i[4:0]));
            if (z >= 0) begin
                x -= dx; y += dy; z -= ta;
            end else begin
                x += dx; y -= dy; z += ta;
            end
        end
        case (q[1:0])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endtask

    task automatic predict_pose(input logic [23:0] ea, eb, ec, output t_pose p);
        logic [31:0] pa, pb, pc;
        longint ca, sa, cb, sb, cc, sc, ln, lb, lc, bs, bc, cs, ccz, reach, tx, ty, tz;
        logic [15:0] ox, oy, oz;
        pa = body_phase(ea, 0);
        pb = body_phase(eb, 1);
        pc = body_phase(ec, 2);
        trig(pa, ca, sa);
        trig(pb, cb, sb);
        trig(pc, cc, sc);
        ln = longint'(cfg_shadow[REG_BASE_HEIGHT][15:0]);
        lb = longint'(cfg_shadow[REG_LINK_B][15:0]);
        lc = longint'(cfg_shadow[REG_LINK_C][15:0]);
        bs = round_q30(lb * sb);
        bc = round_q30(lb * cb);
        cs = round_q30(lc * sc);
        ccz = round_q30(lc * cc);
        reach = bs + cs;
        tx = round_q30(ca * reach);
        ty = round_q30(sa * reach);
        tz = ln + bc - ccz;
        {oz, oy, ox} = cfg_shadow[REG_ORIGIN];
        p.ang_a = 16'((pa + 32'h8000) >> 16);
        p.ang_b = 16'((pb + 32'h8000) >> 16);
        p.ang_c = 16'((pc + 32'h8000) >> 16);
        p.ex = clamp18(round_q30(ca * bs));
        p.ey = clamp18(round_q30(sa * bs));
        p.ez = clamp18(ln + bc);
        p.tx = clamp18(tx);
        p.ty = clamp18(ty);
        p.tz = clamp18(tz);
        p.wx = clamp18(tx - longint'($signed(ox)));
        p.wy = clamp18(ty - longint'($signed(oy)));
        p.wz = clamp18(tz - longint'($signed(oz)));
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [47:0] val);
        logic [47:0] m;
        case (idx)
            REG_BASE_HEIGHT, REG_LINK_B, REG_LINK_C: m = 48'hFFFF;
            REG_GAIN_A, REG_GAIN_B, REG_GAIN_C:      m = 48'hFF_FFFF;
            default:                                 m = '1;
        endcase
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_shadow[idx] = val & m;
        @(posedge i_clk);
    endtask

    // waits for all results, then lets the pipeline drain before touching registers
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (STAGES + 12) @(posedge i_clk);
    endtask

    task automatic send_pose(input logic [23:0] ea, eb, ec);
        t_pose p;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        predict_pose(ea, eb, ec, p);
        i_valid <= 1'b1;
        i_encoder_a <= ea;
        i_encoder_b <= eb;
        i_encoder_c <= ec;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_poses.push_back(p);
        items_sent++;
    endtask

    // result checker
    initial begin
        t_pose e;
        int hold;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (expected_poses.size() == 0) begin
                $error("result with no item pending");
                errors++;
            end else begin
                e = expected_poses.pop_front();
                poses_checked++;
                if (o_angle_a !== e.ang_a) begin
                    $error("angle_a exp %0d got %0d", e.ang_a, o_angle_a); errors++; end
                if (o_angle_b !== e.ang_b) begin
                    $error("angle_b exp %0d got %0d", e.ang_b, o_angle_b); errors++; end
                if (o_angle_c !== e.ang_c) begin
                    $error("angle_c exp %0d got %0d", e.ang_c, o_angle_c); errors++; end
                if (o_elbow_x !== e.ex) begin
                    $error("elbow_x exp %0d got %0d", e.ex, o_elbow_x); errors++; end
                if (o_elbow_y !== e.ey) begin
                    $error("elbow_y exp %0d got %0d", e.ey, o_elbow_y); errors++; end
                if (o_elbow_z !== e.ez) begin
                    $error("elbow_z exp %0d got %0d", e.ez, o_elbow_z); errors++; end
                if (o_tip_x !== e.tx) begin
                    $error("tip_x exp %0d got %0d", e.tx, o_tip_x); errors++; end
                if (o_tip_y !== e.ty) begin
                    $error("tip_y exp %0d got %0d", e.ty, o_tip_y); errors++; end
                if (o_tip_z !== e.tz) begin
                    $error("tip_z exp %0d got %0d", e.tz, o_tip_z); errors++; end
                if (o_tip_ws_x !== e.wx) begin
                    $error("tip_ws_x exp %0d got %0d", e.wx, o_tip_ws_x); errors++; end
                if (o_tip_ws_y !== e.wy) begin
                    $error("tip_ws_y exp %0d got %0d", e.wy, o_tip_ws_y); errors++; end
                if (o_tip_ws_z !== e.wz) begin
                    $error("tip_ws_z exp %0d got %0d", e.wz, o_tip_ws_z); errors++; end
            end
        end
    end

    task automatic test_extremes();
        logic [23:0] ext [5] = '{24'h80_0000, 24'h7F_FFFF, 24'h0, 24'hFF_FFFF, 24'h1};
        int i;
        for (i = 0; i < 5; i++) send_pose(ext[i], ext[(i + 1) % 5], ext[(i + 2) % 5]);
        // encoders near both ends of the 24-bit range; the reset home offsets do not wrap the count
        send_pose(24'h7F_FFF0, 24'h80_0005, 24'h7F_FFFF);
        drain();
    endtask

    task automatic test_saturation();
        // long links, large origin: coordinates clip at both ends
        write_reg(REG_BASE_HEIGHT, 48'hFFFF);
        write_reg(REG_LINK_B, 48'hFFFF);
        write_reg(REG_LINK_C, 48'hFFFF);
        write_reg(REG_ORIGIN, 48'h8000_7FFF_8000);
        send_pose(24'h0, 24'h0, 24'h0);
        send_pose(24'h1000, 24'h2000, 24'h3000);
        send_pose(24'hFF_F000, 24'h00_5000, 24'hFF_9000);
        drain();
        write_reg(REG_ORIGIN, 48'h7FFF_8000_7FFF);
        send_pose(24'h0, 24'hFF_E000, 24'h4000);
        send_pose(24'h2345, 24'h6789, 24'hABCD);
        drain();
    endtask

    task automatic test_gains();
        // extreme gains make the phase wrap through full turns
        write_reg(REG_GAIN_A, 48'h7F_FFFF);
        write_reg(REG_GAIN_B, 48'h80_0000);
        write_reg(REG_GAIN_C, 48'h00_0001);
        write_reg(REG_HOME, 48'h8000_7FFF_FFFF);
        send_pose(24'h7F_FFFF, 24'h80_0000, 24'h12_3456);
        send_pose(24'h80_0000, 24'h7F_FFFF, 24'hFF_FFFF);
        send_pose(24'h00_0100, 24'h00_0200, 24'h40_0000);
        drain();
        write_reg(REG_BASE_HEIGHT, 48'h0);
        write_reg(REG_LINK_B, 48'h0);
        write_reg(REG_LINK_C, 48'h0);
        write_reg(REG_HOME, 48'h0);
        send_pose(24'h55_5555, 24'hAA_AAAA, 24'h33_3333);
        drain();
    endtask

    task automatic test_random(input int n);
        int k, j, idx;
        for (k = 0; k < n; k++) begin
            if (k % 100 == 0) begin
                drain();
                for (j = 0; j < 3; j++) begin
                    idx = $urandom_range(0, 7);
                    write_reg(idx[IDX_W-1:0], 48'({$urandom, $urandom}));
                end
                // keep the kinematics mostly in range
                if (k % 200 == 0) begin
                    write_reg(REG_LINK_B, 48'($urandom_range(0, 20000)));
                    write_reg(REG_LINK_C, 48'($urandom_range(0, 20000)));
                end
            end
            if (k == n / 2) begin
                // hold off until the pipeline is empty
                i_valid <= 1'b0;
                while (expected_poses.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 1))
                send_pose(24'($urandom), 24'($urandom), 24'($urandom));
            else
                send_pose(24'($urandom_range(0, 8191) - 4096),
                          24'($urandom_range(0, 8191) - 4096),
                          24'($urandom_range(0, 8191) - 4096));
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_encoder_a = '0;
        i_encoder_b = '0;
        i_encoder_c = '0;
        cfg_shadow[REG_BASE_HEIGHT] = RST_BASE_HEIGHT;
        cfg_shadow[REG_LINK_B] = RST_LINK_B;
        cfg_shadow[REG_LINK_C] = RST_LINK_C;
        cfg_shadow[REG_GAIN_A] = RST_GAIN_A;
        cfg_shadow[REG_GAIN_B] = RST_GAIN_B;
        cfg_shadow[REG_GAIN_C] = RST_GAIN_C;
        cfg_shadow[REG_HOME] = RST_HOME;
        cfg_shadow[REG_ORIGIN] = RST_ORIGIN;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_saturation();
        test_gains();
        test_random(1080);
        $display("Sent %0d encoder items, checked %0d poses over random register settings.",
                 items_sent, poses_checked);
        if (errors == 0 && expected_poses.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
